@@ rtl/sfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, types and register indexes of the frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // frame layout
  localparam int FRAME_LENGTH = 25;
  localparam int STORE_LEN    = FRAME_LENGTH - 1;
  localparam int FLAG_INDEX   = 22;
  localparam int FAILSAFE_BIT = 3;
  // only the channel bytes and the flag byte are ever read back
  localparam int DECODE_LEN   = FLAG_INDEX + 1;
  localparam int POS_W        = $clog2(FRAME_LENGTH);
  localparam int BIDX_W       = $clog2(DECODE_LEN);

  // channels
  localparam int NUM_CHANNELS = 8;
  localparam int OUT_CHANNELS = 8;
  localparam int CHAN_W       = 11;
  localparam int PULSE_W      = 12;
  localparam logic [PULSE_W-1:0] PULSE_OFFSET = 12'd880;

  // configuration
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAP_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SYNC      = 1'b1;
  localparam logic [15:0] GAP_LIMIT_RST = 16'd2500;
  localparam logic [7:0]  SYNC_RST      = 8'h0F;

  typedef logic [DECODE_LEN-1:0][7:0] sfr_frame_t;

  typedef struct packed {
    logic [OUT_CHANNELS-1:0][PULSE_W-1:0] pulse;
    logic                                 failsafe;
  } sfr_result_t;

endpackage

@@ rtl/sfr_frame_assembler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_frame_assembler
// Gap check, frame position tracking and storage of the frame bytes.
// ----------------------------------------------------------------------------
module sfr_frame_assembler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           accept,
  input  logic [7:0]                     data_byte,
  input  logic [31:0]                    arrival_time_us,
  output sfr_pkg::sfr_frame_t            frame,
  output logic                           frame_done
);
  import sfr_pkg::*;

  logic [15:0]      gap_limit_r;
  logic [7:0]       sync_r;
  logic [31:0]      last_arrival_r, last_arrival_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  sfr_frame_t       frame_r;

  logic [31:0]      gap;
  logic             gap_reset;
  logic [POS_W-1:0] pos_eff;
  logic             store_en;
  logic [POS_W-1:0] store_pos;
  logic [BIDX_W-1:0] store_idx;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= GAP_LIMIT_RST;
      sync_r      <= SYNC_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IDX_GAP_LIMIT: gap_limit_r <= cfg_data;
        CFG_IDX_SYNC:      sync_r      <= cfg_data[7:0];
        default:           ;
      endcase
    end
  end

  // inter-byte gap, wrapping subtraction
  assign gap       = arrival_time_us - last_arrival_r;
  assign gap_reset = gap > {16'd0, gap_limit_r};
  assign pos_eff   = gap_reset ? '0 : pos_r;

  // position sequencing
  always_comb begin
    last_arrival_nxt = last_arrival_r;
    pos_nxt          = pos_r;
    frame_done       = 1'b0;
    if (accept) begin
      last_arrival_nxt = arrival_time_us;
      priority if (pos_eff == '0 && data_byte != sync_r) begin
        pos_nxt = '0;
      end else if (pos_eff < POS_W'(FRAME_LENGTH - 1)) begin
        pos_nxt = pos_eff + 1'b1;
      end else begin
        pos_nxt    = '0;
        frame_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_arrival_r <= '0;
      pos_r          <= '0;
    end else begin
      last_arrival_r <= last_arrival_nxt;
      pos_r          <= pos_nxt;
    end
  end

  // byte store, the trailing end byte is never read so it is not kept
  assign store_pos = pos_eff - 1'b1;
  assign store_idx = store_pos[BIDX_W-1:0];
  assign store_en  = accept && pos_eff != '0 && store_pos < POS_W'(DECODE_LEN);

  always_ff @(posedge clk) begin
    if (store_en) begin
      frame_r[store_idx] <= data_byte;
    end
  end

  assign frame = frame_r;

  // position never leaves the frame
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < POS_W'(FRAME_LENGTH))
    else $error("frame position out of range");

  // a completed frame always restarts at the sync position
  a_done_restart: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> pos_r == '0)
    else $error("position not cleared after frame end");

endmodule

@@ rtl/sfr_channel_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_channel_decoder
// Unpacks the 11-bit channels, scales them to microseconds, applies failsafe.
// ----------------------------------------------------------------------------
module sfr_channel_decoder (
  input  sfr_pkg::sfr_frame_t  frame,
  output sfr_pkg::sfr_result_t result
);
  import sfr_pkg::*;

  logic [DECODE_LEN*8-1:0] bits;
  logic                    fs;

  // bytes laid out little-endian, first byte after sync at bit 0
  assign bits = frame;
  assign fs   = frame[FLAG_INDEX][FAILSAFE_BIT];

  for (genvar ch = 0; ch < OUT_CHANNELS; ch++) begin : g_chan
    logic [CHAN_W-1:0]  raw;
    logic [CHAN_W+2:0]  times5;
    logic [PULSE_W-1:0] pulse;

    assign raw    = bits[ch*CHAN_W +: CHAN_W];
    // 0.625 * x as (5 * x) >> 3
    assign times5 = {1'b0, raw, 2'b00} + {3'b000, raw};
    assign pulse  = {1'b0, times5[CHAN_W+2:3]} + PULSE_OFFSET;

    assign result.pulse[ch] = (!fs && ch < NUM_CHANNELS) ? pulse : '0;
  end

  assign result.failsafe = fs;

endmodule

@@ rtl/sfr_result_buffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_result_buffer
// Output register with a skid stage so input flow control stays registered.
// ----------------------------------------------------------------------------
module sfr_result_buffer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sfr_pkg::sfr_result_t push_res,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sfr_pkg::sfr_result_t out_res
);
  import sfr_pkg::*;

  logic        out_vld_r, out_vld_nxt;
  logic        skid_vld_r, skid_vld_nxt;
  sfr_result_t out_res_r, out_res_nxt;
  sfr_result_t skid_res_r, skid_res_nxt;
  logic        pop;

  assign pop = out_vld_r && !out_stall;

  // next-state of the two entries
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    priority if (pop || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = push;
        out_res_nxt = push_res;
      end
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_res_nxt = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  // the skid entry is only used behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry valid with empty output register");

  // no result may arrive while the skid entry is occupied
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_vld_r)
    else $error("result pushed into full buffer");

endmodule

@@ rtl/sbus_frame_receiver_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_receiver_unit
// Byte-serial frame receiver: gap-framed bytes in, decoded channel beats out.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: one received byte and its microsecond arrival time per
//   beat (in_valid / in_stall). A byte is taken every cycle while in_stall is
//   low; the position counter and gap check update in the cycle of the beat.
//   A byte arriving more than gap_limit_us after the previous one restarts the
//   frame; a frame opens on sync_value and closes on the 25th byte.
//   Output channel: one beat per completed frame (eight pulse widths and the
//   failsafe flag), presented from the output register after the closing
//   byte is accepted. Throughput is one byte per cycle while in_stall is low.
//   When out_stall holds a result, one further result can wait in a skid
//   entry; in_stall is raised only while that entry is occupied, and drops
//   once the output beat is taken.
//   Configuration: cfg_wr_en with cfg_index 0 writes gap_limit_us, index 1
//   writes sync_value; write only while no frame is in progress.
//   Reset (rst_n low, synchronous) restores gap limit 2500 and sync 0x0F,
//   clears the position and last arrival time and empties the output.
//   No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sbus_frame_receiver_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
  // byte input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic [31:0]                    in_arrival_time_us,
  // decoded frame output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sfr_pkg::PULSE_W-1:0]    out_pulse_ch0,
  output logic [sfr_pkg::PULSE_W-1:0]    out_pulse_ch1,
  output logic [sfr_pkg::PULSE_W-1:0]    out_pulse_ch2,
  output logic [sfr_pkg::PULSE_W-1:0]    out_pulse_ch3,
  output logic [sfr_pkg::PULSE_W-1:0]    out_pulse_ch4,
  output logic [sfr_pkg::PULSE_W-1:0]    out_pulse_ch5,
  output logic [sfr_pkg::PULSE_W-1:0]    out_pulse_ch6,
  output logic [sfr_pkg::PULSE_W-1:0]    out_pulse_ch7,
  output logic                           out_failsafe
);
  import sfr_pkg::*;

  logic        accept;
  logic        frame_done;
  logic        buf_full;
  sfr_frame_t  frame;
  sfr_result_t dec_res;
  sfr_result_t out_res;

  // input handshake
  assign accept   = in_valid && !in_stall;
  assign in_stall = buf_full;

  sfr_frame_assembler u_assembler (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .accept          (accept),
    .data_byte       (in_data_byte),
    .arrival_time_us (in_arrival_time_us),
    .frame           (frame),
    .frame_done      (frame_done)
  );

  sfr_channel_decoder u_decoder (
    .frame  (frame),
    .result (dec_res)
  );

  sfr_result_buffer u_result_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (frame_done),
    .push_res  (dec_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // result fields
  assign out_pulse_ch0 = out_res.pulse[0];
  assign out_pulse_ch1 = out_res.pulse[1];
  assign out_pulse_ch2 = out_res.pulse[2];
  assign out_pulse_ch3 = out_res.pulse[3];
  assign out_pulse_ch4 = out_res.pulse[4];
  assign out_pulse_ch5 = out_res.pulse[5];
  assign out_pulse_ch6 = out_res.pulse[6];
  assign out_pulse_ch7 = out_res.pulse[7];
  assign out_failsafe  = out_res.failsafe;

endmodule

@@ verif/sbus_frame_receiver_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_receiver_unit_tb
// Self-checking bench for the byte-serial frame receiver. Timestamped bytes
// go in with random bursts and gaps, and the receiver stalls on a pattern of
// its own. A behavioural decoder predicts each decoded frame beat, and the
// monitor compares every field against the oldest prediction. Directed
// frames cover full scale, failsafe, timestamp wrap and gap restart. Random
// phases then run at several gap-limit and sync settings, extremes included,
// and one long output hold fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module sbus_frame_receiver_unit_tb;
  import sfr_pkg::*;

  localparam int PERIOD_HALF   = 4;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 245;
  localparam int HOLD_CYCLES   = 600;
  localparam int QUIET_LIMIT   = 4000;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic [31:0] in_arrival_time_us;

  logic               out_valid;
  logic               out_stall;
  logic [PULSE_W-1:0] out_pulse_ch0;
  logic [PULSE_W-1:0] out_pulse_ch1;
  logic [PULSE_W-1:0] out_pulse_ch2;
  logic [PULSE_W-1:0] out_pulse_ch3;
  logic [PULSE_W-1:0] out_pulse_ch4;
  logic [PULSE_W-1:0] out_pulse_ch5;
  logic [PULSE_W-1:0] out_pulse_ch6;
  logic [PULSE_W-1:0] out_pulse_ch7;
  logic               out_failsafe;

  sbus_frame_receiver_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_arrival_time_us (in_arrival_time_us),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pulse_ch0      (out_pulse_ch0),
    .out_pulse_ch1      (out_pulse_ch1),
    .out_pulse_ch2      (out_pulse_ch2),
    .out_pulse_ch3      (out_pulse_ch3),
    .out_pulse_ch4      (out_pulse_ch4),
    .out_pulse_ch5      (out_pulse_ch5),
    .out_pulse_ch6      (out_pulse_ch6),
    .out_pulse_ch7      (out_pulse_ch7),
    .out_failsafe       (out_failsafe)
  );

  // clock
  always #PERIOD_HALF clk = ~clk;

  // decoder copy: configuration and frame state
  logic [15:0] gap_limit    = GAP_LIMIT_RST;
  logic [7:0]  sync_byte    = SYNC_RST;
  logic [31:0] prev_arrival = '0;
  int unsigned frame_pos    = 0;
  logic [7:0]  frame_store [STORE_LEN];

  sfr_result_t pending_frames [$];
  sfr_result_t beat_want;
  sfr_result_t beat_got;

  // sender and receiver pacing
  logic [31:0] now_us     = '0;
  int          burst_left = 0;
  bit          no_idle    = 1'b0;
  bit          hold_req   = 1'b0;

  int err_count    = 0;
  int bytes_sent   = 0;
  int frames_seen  = 0;
  int quiet_cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("frame beat %0d: %s got %0d expected %0d", frames_seen, what, got, want);
    err_count++;
  endtask

  // advance the decoder by one accepted byte, queue a beat when a frame closes
  task automatic track_frame_byte(input logic [7:0] value, input logic [31:0] stamp);
    sfr_result_t                frame;
    logic [8*FLAG_INDEX-1:0]    chan_bits;
    logic [CHAN_W-1:0]          raw;
    logic [PULSE_W-1:0]         scaled;
    logic                       fs;
    if (stamp - prev_arrival > {16'd0, gap_limit}) frame_pos = 0;
    prev_arrival = stamp;
    if (frame_pos != 0 || value == sync_byte) begin
      if (frame_pos != 0) frame_store[frame_pos - 1] = value;
      if (frame_pos < FRAME_LENGTH - 1) begin
        frame_pos++;
      end else begin
        frame_pos = 0;
        fs = frame_store[FLAG_INDEX][FAILSAFE_BIT];
        for (int i = 0; i < FLAG_INDEX; i++) chan_bits[i*8 +: 8] = frame_store[i];
        for (int c = 0; c < OUT_CHANNELS; c++) begin
          raw = chan_bits[c*CHAN_W +: CHAN_W];
          scaled = PULSE_W'((5 * raw) >> 3);
          if (fs || c >= NUM_CHANNELS) frame.pulse[c] = '0;
          else frame.pulse[c] = scaled + PULSE_OFFSET;
        end
        frame.failsafe = fs;
        pending_frames.push_back(frame);
      end
    end
  endtask

  // time steps that keep a frame together
  function automatic logic [31:0] within_gap();
    case ($urandom_range(0, 7))
      0:       within_gap = {16'd0, gap_limit};
      1:       within_gap = '0;
      default: within_gap = $urandom_range(0, gap_limit);
    endcase
  endfunction

  // time steps that restart the frame position
  function automatic logic [31:0] past_gap();
    case ($urandom_range(0, 3))
      0:       past_gap = gap_limit + 32'd1;
      1:       past_gap = gap_limit + 32'd1 + $urandom_range(0, 32'hFFFE0000);
      default: past_gap = gap_limit + 32'd1 + $urandom_range(0, 5000);
    endcase
  endfunction

  function automatic logic [7:0] pick_payload_byte();
    case ($urandom_range(0, 7))
      0:       pick_payload_byte = 8'h00;
      1:       pick_payload_byte = 8'hFF;
      default: pick_payload_byte = 8'($urandom);
    endcase
  endfunction

  // one input beat, with burst gaps ahead of it
  task automatic send_byte(input logic [7:0] value, input logic [31:0] delta);
    int gap;
    if (!no_idle && burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    now_us += delta;
    in_valid           <= 1'b1;
    in_data_byte       <= value;
    in_arrival_time_us <= now_us;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_frame_byte(value, now_us);
    bytes_sent++;
  endtask

  // register writes, only with the block idle
  task automatic set_config(input logic [15:0] gap, input logic [7:0] sync);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_GAP_LIMIT;
    cfg_data  <= gap;
    @(posedge clk);
    cfg_index <= CFG_IDX_SYNC;
    cfg_data  <= {8'd0, sync};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gap_limit = gap;
    sync_byte = sync;
  endtask

  // park the position at zero, then wait for every beat to drain and let the block settle
  task automatic close_frame_and_drain();
    send_byte(~sync_byte, past_gap());
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_fixed_frame(input logic [7:0] fill, input logic [7:0] flag,
                                  input logic [7:0] tail, input logic [31:0] open_delta,
                                  input logic [31:0] step);
    send_byte(sync_byte, open_delta);
    repeat (FLAG_INDEX) send_byte(fill, step);
    send_byte(flag, step);
    send_byte(tail, step);
  endtask

  // mostly whole frames with random content; the rest cut short, broken or noise
  task automatic send_random_frame(input bit whole);
    int          kind;
    int          stop_at;
    int          n;
    logic [7:0]  value;
    logic [31:0] delta;
    kind    = whole ? 0 : $urandom_range(0, 11);
    stop_at = (kind >= 9) ? $urandom_range(0, STORE_LEN - 2) : STORE_LEN - 1;
    if (kind == 11) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom), $urandom_range(0, 1) ? within_gap() : past_gap());
    end else begin
      send_byte(sync_byte, ($urandom_range(0, 4) == 0) ? within_gap() : past_gap());
      for (int i = 0; i < STORE_LEN; i++) begin
        value = pick_payload_byte();
        if (i == FLAG_INDEX) value[FAILSAFE_BIT] = ($urandom_range(0, 3) == 0);
        delta = (kind == 10 && i == stop_at + 1) ? past_gap() : within_gap();
        if (kind != 9 || i <= stop_at) send_byte(value, delta);
      end
    end
  endtask

  task automatic run_random_phase(input logic [15:0] gap, input logic [7:0] sync);
    int start;
    set_config(gap, sync);
    start = bytes_sent;
    while (bytes_sent - start < PHASE_ITEMS) send_random_frame(1'b0);
    close_frame_and_drain();
  endtask

  // reset settings: full scale, failsafe across the timestamp wrap, gap restart
  task automatic test_default_frames();
    send_byte(8'h00, 32'd10);
    send_fixed_frame(8'hFF, 8'hF7, 8'hFF, 32'd2501, 32'd2500);
    send_fixed_frame(8'h00, 8'h08, 8'h00, 32'hFFFF_FF00 - now_us, 32'd20);
    send_byte(sync_byte, 32'd100);
    repeat (3) send_byte(8'hA5, 32'd1);
    send_fixed_frame(8'h00, 8'h00, 8'h00, 32'd2501, 32'd1);
    close_frame_and_drain();
  endtask

  task automatic test_config_extremes();
    run_random_phase(16'd0, 8'h00);
    run_random_phase(16'hFFFF, 8'hFF);
  endtask

  task automatic test_random_settings();
    run_random_phase(GAP_LIMIT_RST, SYNC_RST);
    repeat (3) run_random_phase(16'($urandom), 8'($urandom));
  endtask

  // long output hold while whole frames keep coming, until input stalls
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    no_idle  = 1'b1;
    repeat (5) send_random_frame(1'b1);
    no_idle  = 1'b0;
    close_frame_and_drain();
  endtask

  // receiver stall pattern, with a long hold on request
  initial begin : rx_stall_gen
    int seg_len;
    int pct;
    int k;
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        seg_len = $urandom_range(10, 120);
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 25;
          2:       pct = 60;
          default: pct = 90;
        endcase
        k = 0;
        while (k < seg_len && !hold_req) begin
          @(posedge clk);
          if (!hold_req) out_stall <= ($urandom_range(0, 99) < pct);
          k++;
        end
      end
    end
  end

  // output beat checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("beat with nothing pending", 32'd1, 32'd0);
      end else begin
        beat_want = pending_frames.pop_front();
        beat_got.pulse = {out_pulse_ch7, out_pulse_ch6, out_pulse_ch5, out_pulse_ch4,
                          out_pulse_ch3, out_pulse_ch2, out_pulse_ch1, out_pulse_ch0};
        beat_got.failsafe = out_failsafe;
        for (int c = 0; c < OUT_CHANNELS; c++) begin
          if (beat_got.pulse[c] !== beat_want.pulse[c])
            report_mismatch($sformatf("pulse_ch%0d", c), 32'(beat_got.pulse[c]),
                            32'(beat_want.pulse[c]));
        end
        if (beat_got.failsafe !== beat_want.failsafe)
          report_mismatch("failsafe", 32'(beat_got.failsafe), 32'(beat_want.failsafe));
      end
      frames_seen++;
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sbus_frame_receiver_unit test failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= CFG_IDX_GAP_LIMIT;
    cfg_data           <= '0;
    in_valid           <= 1'b0;
    in_data_byte       <= '0;
    in_arrival_time_us <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_default_frames();
    test_config_extremes();
    test_random_settings();
    test_output_backpressure();
    if (err_count == 0 && pending_frames.size() == 0)
      $display("sbus_frame_receiver_unit test passed");
    else
      $display("sbus_frame_receiver_unit test failed");
    $finish;
  end

endmodule
